// File: hw/rtl/stbs_pkg.sv
// Shared constants, types and field widths of the sorted table search unit.
// Depends on nothing; the engine and the top level refer to it by scoped names.
`default_nettype none

package stbs_pkg;

    // table geometry
    localparam int TABLE_DEPTH = 1024;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);

    // field widths of the request and result items
    localparam int DATA_W      = 32;
    localparam int FIELD_IDX_W = 10;
    localparam int LEN_W       = 11;
    localparam int PROBE_W     = 4;

    // signed search bounds: must hold -1 up to the larger of length and depth
    localparam int CNT_W = ((LEN_W > IDX_W + 1) ? LEN_W : IDX_W + 1) + 1;

    // probe counter stops at its top value
    localparam logic [PROBE_W-1:0] PROBES_MAX = '1;

    // stream payload widths, padded to whole bytes
    localparam int S_TDATA_W = ((FIELD_IDX_W + DATA_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((FIELD_IDX_W + PROBE_W + 7) / 8) * 8;

    // register port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_TABLE_LENGTH = 1'b0;

    // request kinds carried in tuser
    localparam logic REQ_WRITE  = 1'b0;
    localparam logic REQ_SEARCH = 1'b1;

    typedef logic signed [CNT_W-1:0] stbs_cnt_t;

    typedef struct packed {
        logic                   found;
        logic [FIELD_IDX_W-1:0] position;
        logic [PROBE_W-1:0]     probes;
    } stbs_result_t;

endpackage

`default_nettype wire

// File: hw/rtl/stbs_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
`default_nettype none

module stbs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write and registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/stbs_engine.sv
// Binary search sequencer: issues one table read per cycle and narrows the range.
// Depends on stbs_pkg; the table memory sits in the top level.
`default_nettype none

module stbs_engine (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 start,
    input  wire logic signed [stbs_pkg::DATA_W-1:0]   key,
    input  wire logic [stbs_pkg::LEN_W-1:0]           table_length,
    output logic                                      idle,
    output logic                                      rd_en,
    output logic [stbs_pkg::IDX_W-1:0]                rd_addr,
    input  wire logic [stbs_pkg::DATA_W-1:0]          rd_data,
    output logic                                      res_valid,
    output stbs_pkg::stbs_result_t                    res,
    input  wire logic                                 res_ready
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_PROBE,
        S_DONE
    } state_t;

    state_t                                 state_reg, state_next;
    stbs_pkg::stbs_cnt_t                    low_reg, low_next;
    stbs_pkg::stbs_cnt_t                    high_reg, high_next;
    stbs_pkg::stbs_cnt_t                    mid_reg, mid_next;
    logic [stbs_pkg::PROBE_W-1:0]           probes_reg, probes_next;
    logic signed [stbs_pkg::DATA_W-1:0]     key_reg, key_next;
    logic                                   found_reg, found_next;
    logic [stbs_pkg::FIELD_IDX_W-1:0]       pos_reg, pos_next;

    stbs_pkg::stbs_cnt_t                    len_ext;
    stbs_pkg::stbs_cnt_t                    depth_c;
    stbs_pkg::stbs_cnt_t                    n_len;
    logic signed [stbs_pkg::DATA_W-1:0]     entry;

    // number of entries searched, clipped to the table depth
    assign len_ext = stbs_pkg::stbs_cnt_t'(table_length);
    assign depth_c = stbs_pkg::stbs_cnt_t'(stbs_pkg::TABLE_DEPTH);
    assign n_len   = (len_ext > depth_c) ? depth_c : len_ext;
    assign entry   = $signed(rd_data);

    // next-state logic: one probe per cycle, next midpoint read issued at once
    always_comb begin
        state_next  = state_reg;
        low_next    = low_reg;
        high_next   = high_reg;
        mid_next    = mid_reg;
        probes_next = probes_reg;
        key_next    = key_reg;
        found_next  = found_reg;
        pos_next    = pos_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (start) begin
                    key_next    = key;
                    low_next    = '0;
                    high_next   = n_len - stbs_pkg::stbs_cnt_t'(1);
                    mid_next    = high_next >>> 1;
                    probes_next = '0;
                    found_next  = 1'b0;
                    pos_next    = '0;
                    if (n_len == '0) begin
                        state_next = S_DONE;
                    end else begin
                        state_next = S_PROBE;
                    end
                end
            end
            S_PROBE: begin
                if (probes_reg != stbs_pkg::PROBES_MAX) begin
                    probes_next = probes_reg + 1'b1;
                end
                if (key_reg == entry) begin
                    found_next = 1'b1;
                    pos_next   = stbs_pkg::FIELD_IDX_W'(mid_reg[stbs_pkg::IDX_W-1:0]);
                    state_next = S_DONE;
                end else begin
                    if (key_reg < entry) begin
                        high_next = mid_reg - stbs_pkg::stbs_cnt_t'(1);
                    end else begin
                        low_next = mid_reg + stbs_pkg::stbs_cnt_t'(1);
                    end
                    if (low_next > high_next) begin
                        state_next = S_DONE;
                    end else begin
                        mid_next = (low_next + high_next) >>> 1;
                    end
                end
            end
            S_DONE: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
        low_reg    <= low_next;
        high_reg   <= high_next;
        mid_reg    <= mid_next;
        probes_reg <= probes_next;
        key_reg    <= key_next;
        found_reg  <= found_next;
        pos_reg    <= pos_next;
    end

    // table read for the midpoint probed next cycle
    assign rd_en   = (state_next == S_PROBE);
    assign rd_addr = mid_next[stbs_pkg::IDX_W-1:0];

    assign idle         = (state_reg == S_IDLE);
    assign res_valid    = (state_reg == S_DONE);
    assign res.found    = found_reg;
    assign res.position = pos_reg;
    assign res.probes   = probes_reg;

    // probed range is never empty and the midpoint lies inside it
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_PROBE) |-> (low_reg <= high_reg && mid_reg >= low_reg
                                    && mid_reg <= high_reg))
        else $error("probe outside the search range");

    // a search starts with a cleared probe count and a cleared found flag
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE && start) |=> (probes_reg == '0 && found_reg == 1'b0))
        else $error("search started with stale result state");

    // a miss always reports position zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && !res.found) |-> (res.position == '0))
        else $error("miss with nonzero position");

    // every probe cycle bumps the count unless it has topped out
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_PROBE && probes_reg != stbs_pkg::PROBES_MAX)
        |=> (probes_reg == $past(probes_reg) + 1'b1))
        else $error("probe count did not advance");

endmodule

`default_nettype wire

// File: hw/rtl/sorted_table_binary_search_unit.sv
// Top level of the sorted table search unit: stream ports, length register, table RAM.
// Depends on stbs_pkg, stbs_ram and stbs_engine.
`default_nettype none

// Holds a table of up to 1024 signed 32-bit entries kept in ascending order by
// the user. A write request (tuser 0) stores one entry and gives no result.
// A search request (tuser 1) binary searches the first table_length entries,
// clipped to the table depth, and returns found, position and the probe
// count. The table RAM has one registered read port, and each probe uses one
// read; a search occupies the unit until its result is passed to the output
// register. One request is worked on at a time; a finished result waits in
// the output register while the next request is taken. The table comes out
// of reset unwritten and needs no clearing; table_length resets to 0. The
// user must write table_length only while no search is in flight; the block
// itself does not enforce this.
module sorted_table_binary_search_unit (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,

    // request stream
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    // s_tdata: entry_index [9:0], data_value [41:10], zero [47:42]
    input  wire logic [stbs_pkg::S_TDATA_W-1:0]       s_tdata,
    // s_tuser: req_type [0]
    input  wire logic                                 s_tuser,

    // result stream
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    // m_tdata: position [9:0], probes [13:10], zero [15:14]
    output logic [stbs_pkg::M_TDATA_W-1:0]            m_tdata,
    // m_tuser: found [0]
    output logic                                      m_tuser,

    // register port
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [stbs_pkg::APB_ADDR_W-1:0]      paddr,
    input  wire logic [stbs_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [stbs_pkg::APB_DATA_W-1:0]           prdata,
    output logic                                      pready
);

    logic [stbs_pkg::LEN_W-1:0]           table_length_reg;
    logic                                 reg_sel;

    logic                                 s_accept;
    logic [stbs_pkg::FIELD_IDX_W-1:0]     entry_index;
    logic signed [stbs_pkg::DATA_W-1:0]   data_value;
    logic                                 start;
    logic                                 wr_en;
    logic [stbs_pkg::IDX_W-1:0]           wr_addr;

    logic                                 eng_idle;
    logic                                 rd_en;
    logic [stbs_pkg::IDX_W-1:0]           rd_addr;
    logic [stbs_pkg::DATA_W-1:0]          rd_data;
    logic                                 res_valid;
    stbs_pkg::stbs_result_t               res;
    logic                                 res_ready;

    logic                                 m_tvalid_reg;
    stbs_pkg::stbs_result_t               m_res_reg;

    // register port: table_length, byte offset ignored
    assign pready  = 1'b1;
    assign reg_sel = paddr[stbs_pkg::APB_ADDR_W-1];
    assign prdata  = (reg_sel == stbs_pkg::REG_TABLE_LENGTH)
                     ? stbs_pkg::APB_DATA_W'(table_length_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            table_length_reg <= '0;
        end else if (psel && penable && pwrite && pready
                     && reg_sel == stbs_pkg::REG_TABLE_LENGTH) begin
            table_length_reg <= pwdata[stbs_pkg::LEN_W-1:0];
        end
    end

    // request unpacking; one request at a time, taken only when the engine is idle
    assign entry_index = s_tdata[stbs_pkg::FIELD_IDX_W-1:0];
    assign data_value  = $signed(s_tdata[stbs_pkg::FIELD_IDX_W +: stbs_pkg::DATA_W]);
    assign s_tready    = eng_idle;
    assign s_accept    = s_tvalid && s_tready;
    assign start       = s_accept && (s_tuser == stbs_pkg::REQ_SEARCH);

    // table writes beyond the depth are dropped
    assign wr_en   = s_accept && (s_tuser == stbs_pkg::REQ_WRITE)
                     && (32'(entry_index) < 32'(stbs_pkg::TABLE_DEPTH));
    assign wr_addr = stbs_pkg::IDX_W'(entry_index);

    stbs_ram #(
        .WIDTH (stbs_pkg::DATA_W),
        .DEPTH (stbs_pkg::TABLE_DEPTH)
    ) u_table (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (data_value),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    stbs_engine u_engine (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .start        (start),
        .key          (data_value),
        .table_length (table_length_reg),
        .idle         (eng_idle),
        .rd_en        (rd_en),
        .rd_addr      (rd_addr),
        .rd_data      (rd_data),
        .res_valid    (res_valid),
        .res          (res),
        .res_ready    (res_ready)
    );

    // output register between the engine and the result stream
    assign res_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_ready) begin
            m_tvalid_reg <= res_valid;
        end
        if (res_ready && res_valid) begin
            m_res_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_res_reg.found;
    assign m_tdata  = stbs_pkg::M_TDATA_W'({m_res_reg.probes, m_res_reg.position});

endmodule

`default_nettype wire
